[rtl/pid_positional_control_defines.svh]
// assertion macros for the positional pid controller
// used by modules that carry concurrent checks; expects clk and rst in scope
`ifndef PID_POSITIONAL_CONTROL_DEFINES_SVH
`define PID_POSITIONAL_CONTROL_DEFINES_SVH

// condition and consequence in the same cycle
`define PID_POS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define PID_POS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pid_pos_pkg.sv]
// shared types and constants for the positional pid controller
// no dependencies; imported by the interfaces, the register file and the top level
`default_nettype none

package pid_pos_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int ERR_W      = 17;
  localparam int DERR_W     = 18;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // product and sum widths
  localparam int PP_W  = GAIN_W + 1 + ERR_W;
  localparam int PI_W  = GAIN_W + 1 + ACC_W;
  localparam int PD_W  = GAIN_W + 1 + DERR_W;
  localparam int SUM_W = 51;
  localparam int RES_W = SUM_W - GAIN_FRAC;

  // separation ranges, zero keeps the term always on
  localparam logic [ERR_W-1:0] I_SEP_RANGE = '0;
  localparam logic [ERR_W-1:0] D_SEP_RANGE = '0;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_GAIN_P    = 3'd0,
    IDX_GAIN_I    = 3'd1,
    IDX_GAIN_D    = 3'd2,
    IDX_DRIVE_MAX = 3'd3,
    IDX_DRIVE_MIN = 3'd4,
    IDX_ACCUM_MAX = 3'd5,
    IDX_ACCUM_MIN = 3'd6
  } cfg_idx_t;

  // configuration register set
  typedef struct packed {
    logic        [GAIN_W-1:0]   gain_p;
    logic        [GAIN_W-1:0]   gain_i;
    logic        [GAIN_W-1:0]   gain_d;
    logic signed [SAMPLE_W-1:0] drive_max;
    logic signed [SAMPLE_W-1:0] drive_min;
    logic signed [ACC_W-1:0]    accum_max;
    logic signed [ACC_W-1:0]    accum_min;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:    16'h0000,
    gain_i:    16'h0000,
    gain_d:    16'h0000,
    drive_max: 16'sh7fff,
    drive_min: 16'sh8000,
    accum_max: 32'sh7fffffff,
    accum_min: 32'sh80000000
  };

endpackage

`default_nettype wire

[rtl/pid_pos_in_if.sv]
// input channel of the positional pid controller: setpoint and measured sample
// depends on pid_pos_pkg for the sample width
`default_nettype none

interface pid_pos_in_if;
  import pid_pos_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] setpoint;
  logic signed [SAMPLE_W-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

`default_nettype wire

[rtl/pid_pos_out_if.sv]
// output channel of the positional pid controller: drive value and clip flag
// depends on pid_pos_pkg for the sample width
`default_nettype none

interface pid_pos_out_if;
  import pid_pos_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] drive;
  logic                       clipped;

  modport source (output valid, output drive, output clipped, input ready);
  modport sink   (input valid, input drive, input clipped, output ready);
endinterface

`default_nettype wire

[rtl/pid_pos_regs.sv]
// configuration register file of the positional pid controller
// decodes the write port into the cfg_t set; depends on pid_pos_pkg
`default_nettype none

module pid_pos_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pid_pos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pid_pos_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pid_pos_pkg::cfg_t                   cfg
);
  import pid_pos_pkg::*;

  cfg_t regs;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        IDX_GAIN_P:    regs.gain_p    <= cfg_data[GAIN_W-1:0];
        IDX_GAIN_I:    regs.gain_i    <= cfg_data[GAIN_W-1:0];
        IDX_GAIN_D:    regs.gain_d    <= cfg_data[GAIN_W-1:0];
        IDX_DRIVE_MAX: regs.drive_max <= cfg_data[SAMPLE_W-1:0];
        IDX_DRIVE_MIN: regs.drive_min <= cfg_data[SAMPLE_W-1:0];
        IDX_ACCUM_MAX: regs.accum_max <= cfg_data[ACC_W-1:0];
        IDX_ACCUM_MIN: regs.accum_min <= cfg_data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

[rtl/pid_positional_control.sv]
// positional pid controller with integral and derivative separation
//
// channels: sample (setpoint, measured) in, result (drive, clipped) out, both
// valid/ready; a word moves on an edge where valid and ready are both high.
// configuration: cfg_we writes cfg_data into register cfg_index (0 gain_p,
// 1 gain_i, 2 gain_d, 3 drive_max, 4 drive_min, 5 accum_max, 6 accum_min);
// write only while no word is in flight.
// pipeline: an accepted word passes the error/accumulator stage, the multiply
// stage and the sum/saturate stage in that order before it shows on result.
// throughput: one word per cycle while result.ready is high; the accumulator
// add and clamp is the only loop and closes at the input stage.
// reset: gains zero, output and accumulator limits at full range,
// accumulator and previous error zero, pipeline empty.
// stall: each stage holds while the next is full and stalled, so the block
// keeps taking words into empty stages while a result waits on result.ready.
// uses pid_pos_pkg, pid_pos_regs and the channel interfaces
`default_nettype none
`include "pid_positional_control_defines.svh"

module pid_positional_control (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pid_pos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pid_pos_pkg::CFG_DATA_W-1:0]  cfg_data,
  pid_pos_in_if.sink                          sample,
  pid_pos_out_if.source                       result
);
  import pid_pos_pkg::*;

  cfg_t cfg;

  pid_pos_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // controller state
  logic signed [ACC_W-1:0] accum;
  logic signed [ERR_W-1:0] last_error;

  // stage valids
  logic s1_valid;
  logic s2_valid;
  logic out_valid;

  // stage payloads
  logic signed [ERR_W-1:0]    err1;
  logic signed [DERR_W-1:0]   derr1;
  logic signed [ACC_W-1:0]    acc1;
  logic                       i_on1;
  logic                       d_on1;
  logic signed [PP_W-1:0]     prod_p;
  logic signed [PI_W-1:0]     prod_i;
  logic signed [PD_W-1:0]     prod_d;
  logic signed [SAMPLE_W-1:0] drive_q;
  logic                       clipped_q;

  // flow control, a stage loads when empty or when it drains this cycle
  logic free1;
  logic free2;
  logic free3;
  logic take;

  assign free3        = !out_valid || result.ready;
  assign free2        = !s2_valid || free3;
  assign free1        = !s1_valid || free2;
  assign sample.ready = free1;
  assign take         = sample.valid && free1;

  // error, derivative difference and separation flags
  logic signed [ERR_W-1:0]  err;
  logic        [ERR_W-1:0]  mag;
  logic signed [DERR_W-1:0] derr;
  logic                     i_on;
  logic                     d_on;

  assign err  = ERR_W'(sample.setpoint) - ERR_W'(sample.measured);
  assign mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign derr = DERR_W'(err) - DERR_W'(last_error);
  assign i_on = (I_SEP_RANGE == '0) || (mag < I_SEP_RANGE);
  assign d_on = (D_SEP_RANGE == '0) || (mag < D_SEP_RANGE);

  // accumulator add and clamp, upper limit first so the lower one wins
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W:0]   acc_hi;
  logic signed [ACC_W-1:0] accum_next;

  always_comb begin
    acc_sum = (ACC_W+1)'(accum) + (ACC_W+1)'(err);
    acc_hi  = (acc_sum > (ACC_W+1)'(cfg.accum_max)) ? (ACC_W+1)'(cfg.accum_max) : acc_sum;
    accum_next = (acc_hi < (ACC_W+1)'(cfg.accum_min)) ? cfg.accum_min : ACC_W'(acc_hi);
  end

  // state and first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      accum      <= '0;
      last_error <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (free1) s1_valid <= sample.valid;
      if (take) begin
        accum      <= accum_next;
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err1  <= err;
      derr1 <= derr;
      acc1  <= accum_next;
      i_on1 <= i_on;
      d_on1 <= d_on;
    end
  end

  // products, gains zero-extended to signed
  logic signed [PP_W-1:0] prod_p_next;
  logic signed [PI_W-1:0] prod_i_next;
  logic signed [PD_W-1:0] prod_d_next;

  always_comb begin
    prod_p_next = PP_W'($signed({1'b0, cfg.gain_p})) * PP_W'(err1);
    prod_i_next = i_on1 ? PI_W'($signed({1'b0, cfg.gain_i})) * PI_W'(acc1) : '0;
    prod_d_next = d_on1 ? PD_W'($signed({1'b0, cfg.gain_d})) * PD_W'(derr1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (free2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free2 && s1_valid) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
  end

  // sum, drop the fraction bits and saturate, upper limit first
  logic signed [SUM_W-1:0]    sum;
  logic signed [RES_W-1:0]    res;
  logic signed [RES_W-1:0]    res_hi;
  logic                       over;
  logic                       under;
  logic signed [SAMPLE_W-1:0] drive_next;

  always_comb begin
    sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    res    = sum[SUM_W-1:GAIN_FRAC];
    over   = res > RES_W'(cfg.drive_max);
    res_hi = over ? RES_W'(cfg.drive_max) : res;
    under  = res_hi < RES_W'(cfg.drive_min);
    drive_next = under ? cfg.drive_min : SAMPLE_W'(res_hi);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free3 && s2_valid) begin
      drive_q   <= drive_next;
      clipped_q <= over || under;
    end
  end

  assign result.valid   = out_valid;
  assign result.drive   = drive_q;
  assign result.clipped = clipped_q;

  // checks
  `PID_POS_ASSERT_NEXT(a_accum_in_limits,
    take && (cfg.accum_min <= cfg.accum_max),
    (accum >= $past(cfg.accum_min)) && (accum <= $past(cfg.accum_max)),
    "accumulator left its clamp range")
  `PID_POS_ASSERT_NEXT(a_drive_in_limits,
    free3 && s2_valid && (cfg.drive_min <= cfg.drive_max),
    (result.drive >= $past(cfg.drive_min)) && (result.drive <= $past(cfg.drive_max)),
    "drive outside its saturation limits")
  `PID_POS_ASSERT_NOW(a_ready_when_drained,
    !out_valid,
    sample.ready,
    "input stalled while the output register is empty")

endmodule

`default_nettype wire
